### sv/etm_pkg.sv
// Shared types, constants and arithmetic helpers of the Euler TRS transform block.
`default_nettype none
package etm_pkg;

    // Restoring divider for 2^24 / |scale|: 25 quotient bits, remainder below 2^16
    localparam int DIV_BITS = 25;
    localparam int REM_W    = 17;

    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [31:0] INV_SAT  = 32'h7FFF_FFFF;
    localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
    localparam logic [31:0] ZERO_Q16 = 32'h0000_0000;

    localparam logic       KIND_MODEL  = 1'b0;
    localparam logic       KIND_NORMAL = 1'b1;
    localparam logic [2:0] COL_LAST    = 3'd6;
    localparam logic [1:0] COL_MOVE    = 2'd3;

    // Horner coefficients of sin(pi/2*x) in Q30, highest order first, signs applied
    localparam logic signed [32:0] KH [5] = '{
        33'sd172272, -33'sd5026995, 33'sd85569305, -33'sd693598669, 33'sd1686629713
    };

    typedef struct packed {
        logic [2:0][15:0] ang;   // x, y, z
        logic [2:0][15:0] sc;    // signed Q8.8
        logic [2:0][31:0] mv;    // signed Q16.16
    } t_item;

    typedef struct packed {
        t_item                      item;
        logic [2:0][REM_W-1:0]      mag;
        logic [2:0][REM_W-1:0]      rem;
        logic [2:0][DIV_BITS-1:0]   num;
    } t_div;

    typedef struct packed {
        logic [2:0][15:0] sc;
        logic [2:0][31:0] inv;
        logic [2:0][31:0] mv;
        logic             zero;
    } t_side;

    // One Horner step: k + floor(p * t / 2^30)
    function automatic logic signed [32:0] hstep(logic signed [32:0] p, logic [30:0] t,
                                                 logic signed [32:0] k);
        logic signed [64:0] m;
        m = p * $signed({1'b0, t});
        return k + 33'(m >>> 30);
    endfunction

endpackage
`default_nettype wire

### sv/etm_div_cell.sv
// One cell of the reciprocal divider chain: one quotient bit for all three scales.
`default_nettype none
module etm_div_cell (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire etm_pkg::t_div i_d,
    output etm_pkg::t_div      o_d
);
    import etm_pkg::*;

    t_div r_d;
    t_div n_d;

    always_comb begin
        logic [REM_W-1:0] tr;
        logic             qb;
        n_d = i_d;
        for (int k = 0; k < 3; k++) begin
            tr = {i_d.rem[k][REM_W-2:0], i_d.num[k][DIV_BITS-1]};
            qb = (tr >= i_d.mag[k]);
            n_d.rem[k] = qb ? (tr - i_d.mag[k]) : tr;
            n_d.num[k] = {i_d.num[k][DIV_BITS-2:0], qb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule
`default_nettype wire

### sv/etm_sine.sv
// Eight-stage pipelined sine/cosine of a binary angle, Horner evaluation in Q30.
`default_nettype none
module etm_sine #(
    parameter int ANGLE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 15,
    parameter bit PHASE          = 1'b0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [15:0]                 i_angle,
    output logic signed [TRIG_FRAC_BITS+1:0] o_sin
);
    import etm_pkg::*;

    localparam int XS = 32 - ANGLE_BITS;
    localparam int SH = 30 - TRIG_FRAC_BITS;
    localparam int OW = TRIG_FRAC_BITS + 2;
    localparam logic [ANGLE_BITS-1:0] PH =
        PHASE ? ANGLE_BITS'(1) << (ANGLE_BITS - 2) : ANGLE_BITS'(0);
    localparam logic [31:0] HALF = (SH > 0) ? (32'd1 << (SH - 1)) : 32'd0;

    logic [ANGLE_BITS-1:0] w_a;
    logic [30:0]           w_x0;
    logic [61:0]           w_xx;
    logic signed [64:0]    w_m;
    logic [30:0]           w_c;
    logic [31:0]           w_r;

    logic [30:0]           r_x1;
    logic                  r_n1;
    logic [30:0]           r_t [5];
    logic [30:0]           r_x [5];
    logic                  r_n [5];
    logic signed [32:0]    r_p [5];
    logic signed [32:0]    r_q;
    logic                  r_n7;
    logic signed [OW-1:0]  r_s;

    // Fold the angle into the first quadrant
    always_comb begin
        w_a  = ANGLE_BITS'(i_angle) + PH;
        w_x0 = 31'(w_a[ANGLE_BITS-3:0]) << XS;
        if (w_a[ANGLE_BITS-2]) begin
            w_x0 = ONE_Q30 - w_x0;
        end
    end

    assign w_xx = r_x1 * r_x1;
    assign w_m  = r_p[4] * $signed({1'b0, r_x[4]});

    always_comb begin
        if (r_q < 0) begin
            w_c = '0;
        end else if (r_q > $signed({2'b00, ONE_Q30})) begin
            w_c = ONE_Q30;
        end else begin
            w_c = r_q[30:0];
        end
        w_r = (32'(w_c) + HALF) >> SH;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1    <= w_x0;
            r_n1    <= w_a[ANGLE_BITS-1];
            r_t[0]  <= w_xx[60:30];
            r_x[0]  <= r_x1;
            r_n[0]  <= r_n1;
            r_p[0]  <= KH[0];
            r_q     <= 33'(w_m >>> 30);
            r_n7    <= r_n[4];
            r_s     <= r_n7 ? -OW'(w_r) : OW'(w_r);
        end
    end

    // Horner cells: each takes the running polynomial one order down
    for (genvar j = 1; j < 5; j++) begin : g_horner
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[j] <= hstep(r_p[j-1], r_t[j-1], KH[j]);
                r_t[j] <= r_t[j-1];
                r_x[j] <= r_x[j-1];
                r_n[j] <= r_n[j-1];
            end
        end
    end

    assign o_sin = r_s;

endmodule
`default_nettype wire

### sv/etm_column.sv
// Column sequencer: scales the rotation per column and emits seven result items.
`default_nettype none
module etm_column #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_load,
    input  wire logic signed [TRIG_FRAC_BITS+2:0] i_rot [3][3],
    input  wire etm_pkg::t_side                i_side,
    output logic                               o_tvalid,
    input  wire logic                          i_tready,
    output logic [127:0]                       o_tdata,
    output logic [3:0]                         o_tuser,
    output logic                               o_tlast
);
    import etm_pkg::*;

    localparam int RW = TRIG_FRAC_BITS + 3;
    localparam int PW = 32 + RW;
    localparam int MS = TRIG_FRAC_BITS - 8;
    localparam logic signed [PW:0] HM =
        (MS > 0) ? ((PW+1)'(1) << (MS - 1)) : (PW+1)'(0);
    localparam logic signed [PW:0] HN = (PW+1)'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic signed [PW:0] MAXV = (PW+1)'(32'sh7FFF_FFFF);
    localparam logic signed [PW:0] MINV = (PW+1)'(32'sh8000_0000);

    logic signed [RW-1:0] r_rot [3][3];
    t_side                r_side;
    logic                 r_busy;
    logic [2:0]           r_idx;
    logic                 r_ovld;
    logic [127:0]         r_data;
    logic [3:0]           r_user;
    logic                 r_last;

    logic                 w_free;
    logic [127:0]         n_data;
    logic [3:0]           n_user;

    function automatic logic [31:0] sat32(logic signed [PW:0] v);
        if (v > MAXV) begin
            return 32'h7FFF_FFFF;
        end else if (v < MINV) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    assign w_free = !r_ovld || i_tready;
    assign o_load = i_valid && (!r_busy || (w_free && r_idx == COL_LAST));

    always_comb begin
        logic               kind;
        logic [1:0]         col;
        logic [1:0]         k;
        logic signed [31:0] f;
        logic signed [PW-1:0] prod;
        logic signed [PW:0] v;
        logic [31:0]        e [4];
        kind = r_idx[2];
        col  = r_idx[1:0];
        k    = (col == COL_MOVE) ? 2'd0 : col;
        f    = (kind == KIND_NORMAL) ? $signed(r_side.inv[k])
                                     : 32'($signed(r_side.sc[k]));
        for (int r = 0; r < 3; r++) begin
            prod = f * r_rot[k][r];
            if (kind == KIND_NORMAL) begin
                v = ((PW+1)'(prod) + HN) >>> TRIG_FRAC_BITS;
            end else begin
                v = ((PW+1)'(prod) + HM) >>> MS;
            end
            e[r] = sat32(v);
        end
        e[3] = ZERO_Q16;
        if (kind == KIND_MODEL && col == COL_MOVE) begin
            for (int r = 0; r < 3; r++) begin
                e[r] = r_side.mv[r];
            end
            e[3] = ONE_Q16;
        end
        n_data = {e[3], e[2], e[1], e[0]};
        n_user = {r_side.zero, col, kind};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (w_free) begin
                r_ovld <= r_busy;
            end
            if (o_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy && w_free) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == COL_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && w_free) begin
            r_data <= n_data;
            r_user <= n_user;
            r_last <= (r_idx == COL_LAST);
        end
        if (o_load) begin
            r_rot  <= i_rot;
            r_side <= i_side;
        end
    end

    assign o_tvalid = r_ovld;
    assign o_tdata  = r_data;
    assign o_tuser  = r_user;
    assign o_tlast  = r_last;

endmodule
`default_nettype wire

### sv/euler_trs_transform_matrix.sv
// Top level of the Euler TRS transform: model and normal matrix columns in fixed point.
// Pipeline: 25 divider cells, 8 sine stages and 3 rotation stages, then the output
//   register of the column sequencer.
// The column sequencer emits one column a cycle while the output is not stalled.
// Items enter back to back while the sequencer drains; the whole pipeline stalls together.
// Reset (synchronous, active low) clears the valid chain and the sequencer; data needs none.
`default_nettype none
module euler_trs_transform_matrix #(
    parameter int ANGLE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // angle_x, angle_y, angle_z, scale_x, scale_y, scale_z, move_x, move_y, move_z
    input  wire logic [191:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // entry_a, entry_b, entry_c, entry_d
    output logic [127:0]      m_axis_tdata,
    // matrix_kind, column[1:0], zero_scale
    output logic [3:0]        m_axis_tuser,
    output logic              m_axis_tlast
);
    import etm_pkg::*;

    localparam int TW   = TRIG_FRAC_BITS + 2;
    localparam int RW   = TRIG_FRAC_BITS + 3;
    localparam int NROT = 11;               // sine stages plus rotation stages
    localparam int NSTG = DIV_BITS + NROT;
    localparam logic signed [2*TW-1:0] HT = (2*TW)'(1) << (TRIG_FRAC_BITS - 1);

    // Product of two trig values, rounded back to the trig format
    function automatic logic signed [TW-1:0] tmul(logic signed [TW-1:0] a,
                                                  logic signed [TW-1:0] b);
        logic signed [2*TW-1:0] m;
        m = a * b;
        return TW'((m + HT) >>> TRIG_FRAC_BITS);
    endfunction

    logic               w_adv;
    logic               w_load;
    logic [NSTG-1:0]    r_vld;
    t_div               w_init;
    t_div               w_div [DIV_BITS];
    t_div               w_dq;
    t_side              n_side;
    t_side              r_side [NROT];

    logic signed [TW-1:0] w_s1, w_c1, w_s2, w_c2, w_s3, w_c3;

    // first product level
    logic signed [TW-1:0] r_s1s2, r_c1s2, r_c1c3, r_c2s3, r_c3s1, r_c1s3;
    logic signed [TW-1:0] r_c2c3, r_s1s3, r_c2s1, r_c1c2, r_s2a, r_s3a, r_c3a;
    // second product level
    logic signed [TW-1:0] r_ss3, r_sc3, r_cs3, r_cc3;
    logic signed [TW-1:0] r_c1c3b, r_c2s3b, r_c3s1b, r_c1s3b, r_c2c3b, r_s1s3b;
    logic signed [TW-1:0] r_c2s1b, r_c1c2b, r_s2b;
    logic signed [RW-1:0] r_rot [3][3];

    // Hold the pipeline while the last stage waits on the sequencer
    assign w_adv         = !r_vld[NSTG-1] || w_load;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], s_axis_tvalid};
        end
    end

    // Unpack the item and set up the dividend 2^24 + |s|/2 for each scale
    always_comb begin
        logic signed [REM_W-1:0] sx;
        w_init.item.ang[0] = s_axis_tdata[15:0];
        w_init.item.ang[1] = s_axis_tdata[31:16];
        w_init.item.ang[2] = s_axis_tdata[47:32];
        w_init.item.sc[0]  = s_axis_tdata[63:48];
        w_init.item.sc[1]  = s_axis_tdata[79:64];
        w_init.item.sc[2]  = s_axis_tdata[95:80];
        w_init.item.mv[0]  = s_axis_tdata[127:96];
        w_init.item.mv[1]  = s_axis_tdata[159:128];
        w_init.item.mv[2]  = s_axis_tdata[191:160];
        for (int k = 0; k < 3; k++) begin
            sx = REM_W'($signed(w_init.item.sc[k]));
            w_init.mag[k] = (sx < 0) ? REM_W'(-sx) : REM_W'(sx);
            w_init.rem[k] = '0;
            w_init.num[k] = (DIV_BITS'(1) << (DIV_BITS - 1)) + DIV_BITS'(w_init.mag[k] >> 1);
        end
    end

    // Divider chain: each cell resolves one quotient bit and hands the item on
    for (genvar c = 0; c < DIV_BITS; c++) begin : g_div
        if (c == 0) begin : g_first
            etm_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_d   (w_init),
                .o_d   (w_div[c])
            );
        end else begin : g_next
            etm_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_d   (w_div[c-1]),
                .o_d   (w_div[c])
            );
        end
    end

    assign w_dq = w_div[DIV_BITS-1];

    // Sign the quotient; saturate the reciprocal of a zero scale and flag it
    always_comb begin
        n_side.sc   = w_dq.item.sc;
        n_side.mv   = w_dq.item.mv;
        n_side.zero = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (w_dq.mag[k] == '0) begin
                n_side.zero   = 1'b1;
                n_side.inv[k] = INV_SAT;
            end else if (w_dq.item.sc[k][15]) begin
                n_side.inv[k] = -32'(w_dq.num[k]);
            end else begin
                n_side.inv[k] = 32'(w_dq.num[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= n_side;
            for (int i = 1; i < NROT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Yaw on y (c1/s1), pitch on x (c2/s2), roll on z (c3/s3)
    etm_sine #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS), .PHASE(1'b0)) u_s1 (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(w_dq.item.ang[1]), .o_sin(w_s1));
    etm_sine #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS), .PHASE(1'b1)) u_c1 (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(w_dq.item.ang[1]), .o_sin(w_c1));
    etm_sine #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS), .PHASE(1'b0)) u_s2 (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(w_dq.item.ang[0]), .o_sin(w_s2));
    etm_sine #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS), .PHASE(1'b1)) u_c2 (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(w_dq.item.ang[0]), .o_sin(w_c2));
    etm_sine #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS), .PHASE(1'b0)) u_s3 (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(w_dq.item.ang[2]), .o_sin(w_s3));
    etm_sine #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS), .PHASE(1'b1)) u_c3 (
        .i_clk(i_clk), .i_en(w_adv), .i_angle(w_dq.item.ang[2]), .o_sin(w_c3));

    // Rotation: two product levels, then the sums
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1s2 <= tmul(w_s1, w_s2);
            r_c1s2 <= tmul(w_c1, w_s2);
            r_c1c3 <= tmul(w_c1, w_c3);
            r_c2s3 <= tmul(w_c2, w_s3);
            r_c3s1 <= tmul(w_c3, w_s1);
            r_c1s3 <= tmul(w_c1, w_s3);
            r_c2c3 <= tmul(w_c2, w_c3);
            r_s1s3 <= tmul(w_s1, w_s3);
            r_c2s1 <= tmul(w_c2, w_s1);
            r_c1c2 <= tmul(w_c1, w_c2);
            r_s2a  <= w_s2;
            r_s3a  <= w_s3;
            r_c3a  <= w_c3;

            r_ss3   <= tmul(r_s1s2, r_s3a);
            r_sc3   <= tmul(r_s1s2, r_c3a);
            r_cs3   <= tmul(r_c1s2, r_s3a);
            r_cc3   <= tmul(r_c1s2, r_c3a);
            r_c1c3b <= r_c1c3;
            r_c2s3b <= r_c2s3;
            r_c3s1b <= r_c3s1;
            r_c1s3b <= r_c1s3;
            r_c2c3b <= r_c2c3;
            r_s1s3b <= r_s1s3;
            r_c2s1b <= r_c2s1;
            r_c1c2b <= r_c1c2;
            r_s2b   <= r_s2a;

            r_rot[0][0] <= RW'(r_c1c3b) + RW'(r_ss3);
            r_rot[0][1] <= RW'(r_c2s3b);
            r_rot[0][2] <= RW'(r_cs3) - RW'(r_c3s1b);
            r_rot[1][0] <= RW'(r_sc3) - RW'(r_c1s3b);
            r_rot[1][1] <= RW'(r_c2c3b);
            r_rot[1][2] <= RW'(r_cc3) + RW'(r_s1s3b);
            r_rot[2][0] <= RW'(r_c2s1b);
            r_rot[2][1] <= -RW'(r_s2b);
            r_rot[2][2] <= RW'(r_c1c2b);
        end
    end

    etm_column #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_column (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld[NSTG-1]),
        .o_load   (w_load),
        .i_rot    (r_rot),
        .i_side   (r_side[NROT-1]),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tuser[0] == KIND_NORMAL && m_axis_tuser[2:1] == 2'd2)
        else $error("last item is not the third normal column");

    a_move_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] == KIND_MODEL && m_axis_tuser[2:1] == COL_MOVE |->
            m_axis_tdata[127:96] == ONE_Q16)
        else $error("translation column lacks the homogeneous one");

    a_hold_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] && !w_adv |=> r_vld[NSTG-1])
        else $error("stalled item dropped from the pipeline tail");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted item missing from the first divider cell");

endmodule
`default_nettype wire
